FILE: src/sli_pkg.sv
// Shared types and codes for the sorted list insert/delete block.
// Holds the beat structs of both channels and the cell command codes.
// No dependencies; compiled first.
package sli_pkg;

	// Input item modes.
	localparam logic [1:0] MODE_INS = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_RD  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOTFD = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// Operations broadcast along the cell row.
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_ROT  = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] entry;
		logic               last;
	} out_t;

	// Command seen by every cell in the same cycle.
	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} cmd_t;

	// Position flags of one cell relative to the fill count.
	typedef struct packed {
		logic occ;    // cell holds a valid entry
		logic at_end; // first free cell
		logic wrap;   // last occupied cell
	} cell_ctl_t;

	// What a cell tells its neighbours and the top level.
	typedef struct packed {
		logic signed [31:0] val;
		logic               gt;
		logic               ge;
		logic               eq;
	} cell_o_t;

endpackage

FILE: src/sli_cell.sv
// One cell of the sorted row: holds a single entry and compares it with the command value.
// Shifts towards either neighbour on insert, delete or readout rotation.
// Depends on sli_pkg.
module sli_cell (
	input  logic               clk,
	input  sli_pkg::cmd_t      cmd,
	input  sli_pkg::cell_ctl_t ctl,
	input  logic               left_gt,
	input  logic signed [31:0] left_val,
	input  logic signed [31:0] right_val,
	input  logic signed [31:0] head_val,
	output sli_pkg::cell_o_t   co
);
	import sli_pkg::*;

	logic signed [31:0] val_q;

	// Compare the stored entry with the command value; empty cells never match.
	always_comb begin
		co.val = val_q;
		co.gt  = ctl.occ && (val_q > cmd.value);
		co.ge  = ctl.occ && (val_q >= cmd.value);
		co.eq  = ctl.occ && (val_q == cmd.value);
	end

	// Entry update: take a neighbour's entry or the new value.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INS: begin
				if (left_gt)
					val_q <= left_val;
				else if (co.gt || ctl.at_end)
					val_q <= cmd.value;
			end
			OP_DEL: begin
				if (co.ge)
					val_q <= right_val;
			end
			OP_ROT: begin
				if (ctl.wrap)
					val_q <= head_val;
				else if (ctl.occ)
					val_q <= right_val;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

FILE: src/sorted_list_insert_delete.sv
// Top level of the sorted list insert/delete block: a row of sli_cell entries and its control.
// Depends on sli_pkg and sli_cell.
//
//   port     dir  width  meaning
//   start    in   1      input beat offered; taken when busy is low
//   busy     out  1      high while a readout is streaming
//   item     in   34     mode and value of the input beat
//   valid    out  1      result beat present for this one cycle
//   result   out  35     status, entry and last of the result beat
//
// Insert and delete are taken at once; their single result appears in the following cycle
// and the next beat can be taken straight away.
// A readout rotates the cell row one place a cycle and holds busy high meanwhile;
// a readout of an empty store gives a single beat.
// Reset clears the fill count and the control; entries themselves are not reset.
// Results cannot be stalled: each is presented for exactly one cycle.
module sorted_list_insert_delete #(
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sli_pkg::in_t  item,
	output logic          valid,
	output sli_pkg::out_t result
);
	import sli_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    rd_idx_q;
	logic             rd_q;
	logic             valid_q;
	out_t             res_q;
	logic             accept;
	logic             full;
	logic             empty;
	logic             found;
	logic             rd_last;
	cmd_t             cmd;
	cell_o_t          co [DEPTH];
	logic [DEPTH-1:0] eq_v;

	assign accept  = start && !busy;
	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign found   = |eq_v;
	assign rd_last = (rd_idx_q == CW'(cnt_q - CW'(1)));

	// Pick the operation broadcast to the row this cycle.
	always_comb begin
		cmd.value = item.value;
		cmd.op    = OP_HOLD;
		if (rd_q)
			cmd.op = OP_ROT;
		else if (accept && item.mode == MODE_INS && !full)
			cmd.op = OP_INS;
		else if (accept && item.mode == MODE_DEL && found)
			cmd.op = OP_DEL;
	end

	// The cell row, each cell linked to both neighbours.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t          ctl;
		logic               lgt;
		logic signed [31:0] lval;
		logic signed [31:0] rval;

		assign ctl.occ    = (CW'(i) < cnt_q);
		assign ctl.at_end = (CW'(i) == cnt_q);
		assign ctl.wrap   = (CW'(i) == CW'(cnt_q - CW'(1)));
		assign eq_v[i]    = co[i].eq;

		if (i == 0) begin : g_first
			assign lgt  = 1'b0;
			assign lval = co[i].val;
		end else begin : g_inner
			assign lgt  = co[i-1].gt;
			assign lval = co[i-1].val;
		end

		if (i == DEPTH - 1) begin : g_lastc
			assign rval = co[i].val;
		end else begin : g_notlast
			assign rval = co[i+1].val;
		end

		sli_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.ctl       (ctl),
			.left_gt   (lgt),
			.left_val  (lval),
			.right_val (rval),
			.head_val  (co[0].val),
			.co        (co[i])
		);
	end

	// Fill count and readout sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_q     <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.op == OP_INS)
				cnt_q <= cnt_q + CW'(1);
			else if (cmd.op == OP_DEL)
				cnt_q <= cnt_q - CW'(1);

			if (rd_q) begin
				rd_idx_q <= rd_idx_q + CW'(1);
				if (rd_last)
					rd_q <= 1'b0;
			end else if (accept && item.mode == MODE_RD && !empty) begin
				rd_q     <= 1'b1;
				rd_idx_q <= '0;
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= rd_q || (accept && (item.mode == MODE_INS || item.mode == MODE_DEL
				|| (item.mode == MODE_RD && empty)));
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (rd_q) begin
			res_q.status <= ST_OK;
			res_q.entry  <= co[0].val;
			res_q.last   <= rd_last;
		end else begin
			res_q.entry <= '0;
			res_q.last  <= 1'b1;
			case (item.mode)
				MODE_INS: res_q.status <= full ? ST_FULL : ST_OK;
				MODE_DEL: res_q.status <= empty ? ST_EMPTY : (found ? ST_OK : ST_NOTFD);
				default:  res_q.status <= ST_EMPTY;
			endcase
		end
	end

	assign busy   = rd_q;
	assign valid  = valid_q;
	assign result = res_q;

	// The fill count never passes the depth of the row.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// A readout only runs over a non-empty store.
	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q |-> !empty)
		else $error("readout running on empty store");

	// Insert and delete give one final beat with a zero entry in the next cycle.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.mode == MODE_INS || item.mode == MODE_DEL))
		|=> (valid && result.last && result.entry == '0))
		else $error("missing single result beat");

	// The final readout beat ends the readout.
	a_rd_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_q && rd_last) |=> (valid && result.last && !rd_q))
		else $error("readout did not end on its last beat");

endmodule

FILE: sim/sorted_list_insert_delete_tb.sv
// Self-checking testbench for the sorted list insert/delete block.
// Holds a scoreboard class that mirrors the ordered store and a set of stimulus tasks.
// Depends on sli_pkg and the sorted_list_insert_delete RTL.
module sorted_list_insert_delete_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sli_pkg::*;

	localparam int DEPTH      = 32;
	localparam int QUIET_MAX  = 1000;
	localparam int SETTLE_CYC = 40;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	// Mirror of the ordered store and the queue of result beats still owed.
	class list_scoreboard;
		logic signed [31:0] held[$];
		out_t owed[$];
		int fails;

		function void owe(logic [1:0] st, logic signed [31:0] ent, logic lst);
			out_t b;
			b.status = st;
			b.entry  = ent;
			b.last   = lst;
			owed.push_back(b);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Update the mirror for one accepted input beat and queue its results.
		function void note_item(in_t b);
			int pos;
			case (b.mode)
				MODE_INS: begin
					if (held.size() >= DEPTH) begin
						owe(ST_FULL, '0, 1'b1);
					end else begin
						// Equal entries stay ahead of the new one.
						pos = 0;
						while (pos < held.size() && held[pos] <= b.value)
							pos++;
						held.insert(pos, b.value);
						owe(ST_OK, '0, 1'b1);
					end
				end
				MODE_DEL: begin
					if (held.size() == 0) begin
						owe(ST_EMPTY, '0, 1'b1);
					end else begin
						pos = 0;
						while (pos < held.size() && held[pos] != b.value)
							pos++;
						if (pos >= held.size()) begin
							owe(ST_NOTFD, '0, 1'b1);
						end else begin
							held.delete(pos);
							owe(ST_OK, '0, 1'b1);
						end
					end
				end
				MODE_RD: begin
					if (held.size() == 0) begin
						owe(ST_EMPTY, '0, 1'b1);
					end else begin
						for (int i = 0; i < held.size(); i++)
							owe(ST_OK, held[i], i == held.size() - 1);
					end
				end
				default: begin
					// The spare mode code is dropped without a result.
				end
			endcase
		endfunction

		task report(string what, logic signed [31:0] got, logic signed [31:0] want);
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
			fails++;
		endtask

		// Compare one result beat with the oldest one owed.
		task check_result(out_t r);
			out_t want;
			if (owed.size() == 0) begin
				report("unexpected result beat", r.entry, 0);
			end else begin
				want = owed.pop_front();
				if (r.status !== want.status)
					report("status", r.status, want.status);
				if (r.entry !== want.entry)
					report("entry", r.entry, want.entry);
				if (r.last !== want.last)
					report("last", r.last, want.last);
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	in_t   item;
	logic  valid;
	out_t  result;

	list_scoreboard sb = new;
	int quiet;
	bit gaps_on;

	sorted_list_insert_delete #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.valid  (valid),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watch both channels at each rising edge; outputs are read before they update.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (valid === 1'b1) begin
				// Only a result that was still owed counts as progress.
				if (sb.pending() != 0)
					moved = 1'b1;
				sb.check_result(result);
			end
			if (start && busy === 1'b0) begin
				sb.note_item(item);
				moved = 1'b1;
			end
			if (moved)
				quiet = 0;
			else
				quiet++;
		end
	end

	// Give up once nothing has moved for too long.
	initial begin
		quiet = 0;
		while (quiet < QUIET_MAX)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// Offer one input beat and hold it until the block takes it.
	task send_beat(logic [1:0] m, logic signed [31:0] v);
		item  <= '{mode: m, value: v};
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task idle_gap(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop offering beats until every owed result has been seen.
	task wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task maybe_gap();
		if (gaps_on && $urandom_range(99) < 28)
			idle_gap($urandom_range(1, 4));
	endtask

	// Values lean towards small numbers, the extremes and entries already held.
	function logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return $signed($urandom_range(8)) - 4;
		if (r < 55) begin
			case ($urandom_range(5))
				0: return VAL_MIN;
				1: return VAL_MIN + 1;
				2: return VAL_MAX;
				3: return VAL_MAX - 1;
				4: return -1;
				default: return 0;
			endcase
		end
		if (r < 70 && sb.held.size() != 0)
			return sb.held[$urandom_range(sb.held.size() - 1)];
		return $urandom;
	endfunction

	function logic signed [31:0] pick_victim();
		if (sb.held.size() != 0 && $urandom_range(99) < 70)
			return sb.held[$urandom_range(sb.held.size() - 1)];
		return pick_value();
	endfunction

	// Directed beats: empty store, extremes, duplicates, misses and the spare code.
	task run_directed();
		send_beat(MODE_RD, 0);
		send_beat(MODE_DEL, 5);
		send_beat(MODE_INS, 0);
		send_beat(MODE_DEL, 0);
		send_beat(MODE_INS, VAL_MAX);
		send_beat(MODE_INS, VAL_MIN);
		send_beat(MODE_INS, -1);
		send_beat(MODE_INS, 0);
		send_beat(MODE_INS, 0);
		send_beat(MODE_INS, 32'sh5555_5555);
		send_beat(MODE_INS, 32'sh2aaa_aaaa);
		send_beat(MODE_RD, 32'sh7fff_ffff);
		send_beat(MODE_DEL, 7);
		send_beat(MODE_DEL, 0);
		send_beat(MODE_SPARE, -1);
		send_beat(MODE_DEL, VAL_MIN);
		send_beat(MODE_DEL, VAL_MAX);
		send_beat(MODE_RD, 0);
		send_beat(MODE_DEL, 32'sh5555_5555);
		send_beat(MODE_DEL, 32'sh2aaa_aaaa);
		send_beat(MODE_DEL, -1);
		send_beat(MODE_DEL, 0);
		send_beat(MODE_RD, 0);
		send_beat(MODE_DEL, 0);
	endtask

	// One random phase with the given insert and delete weights in percent.
	task run_phase(int beats, int ins_pct, int del_pct, bit with_gaps);
		int r;
		gaps_on = with_gaps;
		for (int n = 0; n < beats; n++) begin
			maybe_gap();
			r = $urandom_range(99);
			if (r < ins_pct)
				send_beat(MODE_INS, pick_value());
			else if (r < ins_pct + del_pct)
				send_beat(MODE_DEL, pick_victim());
			else if (r < 97)
				send_beat(MODE_RD, $urandom);
			else
				send_beat(MODE_SPARE, $urandom);
		end
		wait_drained();
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		item    = '0;
		gaps_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		// Fill past full, churn, empty out, churn with no gaps, then refill.
		run_phase(110, 85, 5, 1'b1);
		run_phase(140, 42, 42, 1'b1);
		run_phase(100, 10, 80, 1'b1);
		run_phase(100, 45, 40, 1'b0);
		run_phase(60, 88, 4, 1'b1);

		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		if (sb.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/sli_pkg.sv
src/sli_cell.sv
src/sorted_list_insert_delete.sv
sim/sorted_list_insert_delete_tb.sv
